### rtl/mhs_pkg.sv
// Shared constants, types and action codes of the modulo hash set.
package mhs_pkg;

  localparam int unsigned BUCKETS = 6;
  localparam int unsigned SLOTS   = 8;

  localparam int unsigned KEY_W    = 31;
  localparam int unsigned BUCKET_W = $clog2(BUCKETS);
  localparam int unsigned FILL_W   = $clog2(SLOTS + 1);

  // First reduction: key = hi * 2^16 + lo, folded to hi * (2^16 mod BUCKETS) + lo.
  // With BUCKETS <= 64 the folded value stays below 2^22.
  localparam int unsigned FOLD_LO_W = 16;
  localparam int unsigned FOLD_HI_W = KEY_W - FOLD_LO_W;
  localparam int unsigned FOLD_W    = 22;
  localparam int unsigned FOLD_MUL  = (1 << FOLD_LO_W) % BUCKETS;

  // Second reduction: exact quotient by reciprocal for values below 2^FOLD_W.
  localparam int unsigned    MOD_SHIFT = FOLD_W + $clog2(BUCKETS);
  localparam int unsigned    RECIP_W   = FOLD_W + 1;
  localparam longint unsigned MOD_RECIP =
      ((64'd1 << MOD_SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam int unsigned    PROD_W    = FOLD_W + RECIP_W;
  localparam int unsigned    QUOT_W    = PROD_W - MOD_SHIFT;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_SEARCH = 1'b1
  } mhs_action_e;

  // Item as it travels along the bucket cells.
  typedef struct packed {
    mhs_action_e         action;
    logic [KEY_W-1:0]    key;
    logic [BUCKET_W-1:0] bucket;
    logic                found;
    logic                status;
  } mhs_item_t;

endpackage

### rtl/mhs_req_if.sv
// Request channel: action and key with valid/ready.
interface mhs_req_if import mhs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [KEY_W-1:0] key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

### rtl/mhs_rsp_if.sv
// Response channel: found and status with valid/ready.
interface mhs_rsp_if import mhs_pkg::*; ();
  logic valid;
  logic ready;
  logic found;
  logic status;

  modport source (output valid, output found, output status, input ready);
  modport sink   (input valid, input found, input status, output ready);
endinterface

### rtl/modulo_hash_set_insert_search.sv
// Top level of the modulo hash set: bucket index unit followed by a chain of bucket cells.
// Each request (insert or search of a 31-bit key) yields exactly one response, in request
// order. The key's bucket (key mod BUCKETS) is found in three pipeline stages, then the item
// walks a chain of BUCKETS cells, one register per cell; the cell that owns the bucket appends
// the key if its row has a free slot (else it sets status) or compares it against all filled
// slots of its row at once. One item can enter every cycle while the chain keeps moving;
// every stage has its own ready so a waiting response stalls only what is behind it. Fill
// counts clear at reset; slot keys are not cleared and need no pass.
module modulo_hash_set_insert_search import mhs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  mhs_req_if.sink req_i,
  mhs_rsp_if.source rsp_o
);

  logic      valid [BUCKETS+1];
  logic      ready [BUCKETS+1];
  mhs_item_t item  [BUCKETS+1];

  mhs_hash u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .out_valid_o (valid[0]),
    .out_item_o  (item[0]),
    .out_ready_i (ready[0])
  );

  for (genvar g = 0; g < BUCKETS; g++) begin : g_cell
    mhs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (BUCKET_W'(g)),
      .in_valid_i  (valid[g]),
      .in_item_i   (item[g]),
      .in_ready_o  (ready[g]),
      .out_valid_o (valid[g+1]),
      .out_item_o  (item[g+1]),
      .out_ready_i (ready[g+1])
    );
  end

  assign ready[BUCKETS] = rsp_o.ready;
  assign rsp_o.valid    = valid[BUCKETS];
  assign rsp_o.found    = item[BUCKETS].found;
  assign rsp_o.status   = item[BUCKETS].status;

endmodule

### rtl/mhs_hash.sv
// Three-stage bucket index unit: fold, reciprocal multiply, remainder.
module mhs_hash import mhs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mhs_req_if.sink    req_i,
  output logic       out_valid_o,
  output mhs_item_t  out_item_o,
  input  logic       out_ready_i
);

  logic               v1_q, v2_q, v3_q;
  logic               rdy1, rdy2, rdy3;
  mhs_action_e        a1_q, a2_q;
  logic [KEY_W-1:0]   k1_q, k2_q;
  logic [FOLD_W-1:0]  f1_q, f2_q;
  logic [PROD_W-1:0]  p2_q;
  mhs_item_t          item3_q;

  logic [FOLD_W-1:0]  fold_d;
  logic [PROD_W-1:0]  prod_d;
  logic [QUOT_W-1:0]  quot;
  logic [FOLD_W-1:0]  rem;
  mhs_item_t          item3_d;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign req_i.ready = rdy1;

  always_comb begin
    fold_d = FOLD_W'(req_i.key[KEY_W-1:FOLD_LO_W]) * FOLD_W'(FOLD_MUL)
           + FOLD_W'(req_i.key[FOLD_LO_W-1:0]);
    prod_d = PROD_W'(f1_q) * PROD_W'(MOD_RECIP);
    quot   = p2_q[PROD_W-1:MOD_SHIFT];
    rem    = f2_q - FOLD_W'(FOLD_W'(quot) * FOLD_W'(BUCKETS));
    item3_d.action = a2_q;
    item3_d.key    = k2_q;
    item3_d.bucket = rem[BUCKET_W-1:0];
    item3_d.found  = 1'b0;
    item3_d.status = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= req_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && req_i.valid) begin
      a1_q <= mhs_action_e'(req_i.action);
      k1_q <= req_i.key;
      f1_q <= fold_d;
    end
    if (rdy2 && v1_q) begin
      a2_q <= a1_q;
      k2_q <= k1_q;
      f2_q <= f1_q;
      p2_q <= prod_d;
    end
    if (rdy3 && v2_q) begin
      item3_q <= item3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_item_o  = item3_q;

endmodule

### rtl/mhs_cell.sv
// One bucket cell: slot row, fill count and one pipeline register of the chain.
module mhs_cell import mhs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [BUCKET_W-1:0] cell_idx_i,
  input  logic                in_valid_i,
  input  mhs_item_t           in_item_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output mhs_item_t           out_item_o,
  input  logic                out_ready_i
);

  logic [KEY_W-1:0]  key_q [SLOTS];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              valid_q;
  mhs_item_t         item_q, item_d;
  logic              take, hit, full, match, wr_en;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign hit        = in_item_i.bucket == cell_idx_i;
  assign full       = fill_q == FILL_W'(SLOTS);

  always_comb begin
    match = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      if ((FILL_W'(s) < fill_q) && (key_q[s] == in_item_i.key)) match = 1'b1;
    end
    item_d = in_item_i;
    fill_d = fill_q;
    wr_en  = 1'b0;
    if (hit) begin
      case (in_item_i.action)
        ACT_INSERT: begin
          if (full) begin
            item_d.status = 1'b1;
          end else begin
            wr_en  = take;
            fill_d = fill_q + FILL_W'(1);
          end
        end
        ACT_SEARCH: item_d.found = match;
        default:    item_d = in_item_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fill_q  <= '0;
    end else begin
      if (in_ready_o) valid_q <= in_valid_i;
      if (take)       fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= item_d;
    for (int s = 0; s < SLOTS; s++) begin
      if (wr_en && (fill_q == FILL_W'(s))) key_q[s] <= in_item_i.key;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(SLOTS))
    else $error("bucket fill count beyond slot row");

  a_other_bucket_keeps_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !hit) |=> $stable(fill_q))
    else $error("fill count moved for an item of another bucket");

  a_insert_grows_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && hit && in_item_i.action == ACT_INSERT && !full)
      |=> fill_q == $past(fill_q) + FILL_W'(1))
    else $error("insert into a free slot did not advance the fill count");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !(item_q.found && item_q.status))
    else $error("found and status both set on one item");

endmodule
